// ===== hdl/float_quantize_to_fixed_grid_unit_defines.svh =====
// Assertion macros used by the quantizer top module.
`ifndef FLOAT_QUANTIZE_TO_FIXED_GRID_UNIT_DEFINES_SVH
`define FLOAT_QUANTIZE_TO_FIXED_GRID_UNIT_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define FQG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("quantizer check failed");

// Next-cycle implication checked on every rising edge outside reset.
`define FQG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("quantizer check failed");

`endif

// ===== hdl/fqg_pkg.sv =====
package fqg_pkg;

    // Configuration register indexes.
    localparam logic CFG_INT_BITS  = 1'b0;
    localparam logic CFG_FRAC_BITS = 1'b1;

    localparam logic [4:0] INT_BITS_RESET  = 5'd8;
    localparam logic [4:0] FRAC_BITS_RESET = 5'd8;

    // Grid value on its way to single precision.
    typedef struct packed {
        logic [63:0] n;
        logic [5:0]  p;
        logic [4:0]  f;
        logic        neg;
        logic        sat;
        logic        inv;
    } fqg_grid_t;

endpackage

// ===== hdl/fqg_round.sv =====
module fqg_round (
    input  fqg_pkg::fqg_grid_t grid,
    output logic [31:0]        result
);
    import fqg_pkg::*;

    logic [63:0] aligned;
    logic [23:0] q;
    logic        guard;
    logic        sticky;
    logic        round_up;
    logic [24:0] q_inc;
    logic [8:0]  expo;
    logic [22:0] mant;

    // Bring the leading one to the top, then round to nearest, ties to even.
    always_comb
    begin
        aligned  = grid.n << (6'd63 - grid.p);
        q        = aligned[63:40];
        guard    = aligned[39];
        sticky   = |aligned[38:0];
        round_up = guard && (sticky || q[0]);
        q_inc    = {1'b0, q} + {24'd0, round_up};
        expo     = {3'd0, grid.p} + 9'd127 - {4'd0, grid.f} + {8'd0, q_inc[24]};
        mant     = q_inc[24] ? 23'd0 : q_inc[22:0];
        if (grid.n == 64'd0)
        begin
            result = 32'd0;
        end
        else
        begin
            result = {1'b0, expo[7:0], mant};
        end
        result[31] = result[31] | grid.neg;
    end

endmodule

// ===== hdl/float_quantize_to_fixed_grid_unit.sv =====
// Throughput: one item per cycle while m_tready is high; four registered stages
// advance independently, and the priority encoder over the 64-bit grid word
// has a stage of its own. Reset (rst_n low, asynchronous) empties the pipeline
// and sets int_bits and frac_bits to 8.
`include "float_quantize_to_fixed_grid_unit_defines.svh"
module float_quantize_to_fixed_grid_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // quantized_bits
    output logic [1:0]  m_tuser    // [1] invalid, [0] saturated
);
    import fqg_pkg::*;

    logic [4:0]  int_bits_reg;
    logic [4:0]  frac_bits_reg;
    logic        v0_reg, v1_reg, v2_reg, v3_reg;
    logic        rdy1, rdy2, rdy3;
    logic [31:0] value_reg;
    fqg_grid_t   g1_next, g1_reg, g2_next, g2_reg;
    logic [31:0] res_next, res_reg;
    logic        sat_reg, inv_reg;

    logic [7:0]        expo;
    logic [22:0]       man;
    logic [23:0]       m;
    logic signed [9:0] e;
    logic signed [9:0] sh;
    logic [9:0]        s;
    logic [29:0]       lim;
    logic [54:0]       t;
    logic [54:0]       ip_full;
    logic [54:0]       fmask;
    logic [30:0]       fr;
    logic [29:0]       ip;
    logic              sat;
    logic              is_nan;
    logic              is_inf;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_bits_reg  <= INT_BITS_RESET;
            frac_bits_reg <= FRAC_BITS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INT_BITS:  int_bits_reg  <= cfg_wdata;
                CFG_FRAC_BITS: frac_bits_reg <= cfg_wdata;
                default:       int_bits_reg  <= int_bits_reg;
            endcase
        end
    end

    // Each stage takes a new item when it is empty or its successor takes one.
    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = !v0_reg || rdy1;

    // Stage one: scale, round and clamp onto the grid.
    always_comb
    begin
        expo    = value_reg[30:23];
        man     = value_reg[22:0];
        is_nan  = (expo == 8'hFF) && (man != 23'd0);
        is_inf  = (expo == 8'hFF) && (man == 23'd0);
        m       = (expo == 8'd0) ? {1'b0, man} : {1'b1, man};
        e       = (expo == 8'd0) ? -10'sd149 : ($signed({2'b00, expo}) - 10'sd150);
        sh      = e + $signed({5'd0, frac_bits_reg});
        s       = 10'(-sh);
        lim     = (int_bits_reg <= 5'd1) ? 30'd0
                : ((30'd1 << (int_bits_reg - 5'd1)) - 30'd1);
        fmask   = (55'd1 << frac_bits_reg) - 55'd1;
        t       = 55'd0;
        ip_full = 55'd0;
        fr      = 31'd0;
        sat     = 1'b0;
        if (is_inf)
        begin
            sat = 1'b1;
        end
        else if (e >= 10'sd0)
        begin
            if (e > 10'sd6)
            begin
                sat = 1'b1;
            end
            else
            begin
                ip_full = 55'(m) << e[2:0];
            end
        end
        else
        begin
            if (sh >= 10'sd0)
            begin
                t = 55'(m) << sh[4:0];
            end
            else if (s < 10'd26)
            begin
                t = 55'(({1'b0, m} + (25'd1 << (s[4:0] - 5'd1))) >> s[4:0]);
            end
            ip_full = t >> frac_bits_reg;
            fr      = 31'(t & fmask);
        end
        if (ip_full > 55'(lim))
        begin
            sat = 1'b1;
        end
        ip = sat ? lim : ip_full[29:0];

        g1_next.n   = is_nan ? 64'd0 : ((64'(ip) << frac_bits_reg) | 64'(fr));
        g1_next.p   = 6'd0;
        g1_next.f   = frac_bits_reg;
        g1_next.neg = !is_nan && value_reg[31] && (value_reg[30:0] != 31'd0);
        g1_next.sat = sat && !is_nan;
        g1_next.inv = is_nan;
    end

    // Stage two: position of the leading one.
    always_comb
    begin
        g2_next   = g1_reg;
        g2_next.p = 6'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (g1_reg.n[i])
            begin
                g2_next.p = 6'(i);
            end
        end
    end

    // Stage three: normalise and round to single precision.
    fqg_round u_round (
        .grid   (g2_reg),
        .result (res_next)
    );

    // Valid flags of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                v0_reg <= s_tvalid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload of the stages.
    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            value_reg <= s_tdata;
        end
        if (rdy1)
        begin
            g1_reg <= g1_next;
        end
        if (rdy2)
        begin
            g2_reg <= g2_next;
        end
        if (rdy3)
        begin
            res_reg <= res_next;
            sat_reg <= g2_reg.sat;
            inv_reg <= g2_reg.inv;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = res_reg;
    assign m_tuser  = {inv_reg, sat_reg};

    `FQG_ASSERT_IMP(a_nan_gives_zero, clk, rst_n, m_tvalid && m_tuser[1],
        (m_tdata == 32'd0) && !m_tuser[0])
    `FQG_ASSERT_IMP(a_grid_fits, clk, rst_n, v1_reg, g1_reg.n[63:61] == 3'd0)
    `FQG_ASSERT_IMP(a_leading_one, clk, rst_n, v2_reg && (g2_reg.n != 64'd0),
        (g2_reg.n >> g2_reg.p) == 64'd1)
    `FQG_ASSERT_NEXT(a_stall_holds, clk, rst_n, v3_reg && !m_tready,
        v3_reg && $stable(res_reg))

endmodule
